FILE: rtl/bdms_pkg.sv
package bdms_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_DEPTH  = 16;
    localparam int DEF_MAX_DIST   = 7;

    // One map entry, and the number of entries packed into one memory word.
    localparam int DIST_W = 4;
    localparam int LANES  = 16;
    localparam int LANE_W = $clog2(LANES);

    // Largest root ever looked up: floor(sqrt(3 * 7 * 7)).
    localparam int ROOT_MAX = 12;
    // Largest value an entry can hold: the widest radius plus one.
    localparam logic [DIST_W-1:0] MAX_ENTRY_VALUE = DIST_W'(8);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] CFG_FOREGROUND = 3'd0;
    localparam logic [2:0] CFG_MAX_DIST   = 3'd1;
    localparam logic [2:0] CFG_DIM        = 3'd2;
    localparam logic [2:0] CFG_WIDTH      = 3'd3;
    localparam logic [2:0] CFG_HEIGHT     = 3'd4;
    localparam logic [2:0] CFG_DEPTH      = 3'd5;

    localparam logic [1:0] DIM_CUBE = 2'd3;

    localparam logic [15:0]       RST_FOREGROUND = 16'd1;
    localparam logic [2:0]        RST_MAX_DIST   = 3'd1;
    localparam logic [1:0]        RST_DIM        = 2'd2;
    localparam logic [8:0]        RST_WIDTH      = 9'd256;
    localparam logic [8:0]        RST_HEIGHT     = 9'd256;
    localparam logic [4:0]        RST_DEPTH      = 5'd1;
    localparam logic [DIST_W-1:0] RST_FILL       = DIST_W'(RST_MAX_DIST) + DIST_W'(1);

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_RMW  = 2'd1,
        REQ_READ = 2'd2,
        REQ_FILL = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [DIST_W-1:0] value;
    } map_req_t;

    typedef struct packed {
        logic              busy;
        logic [DIST_W-1:0] rd_value;
    } map_stat_t;

    // floor(sqrt(s)) for the sums of three squares of offsets up to 7.
    function automatic logic [DIST_W-1:0] root_of(input logic [7:0] s);
        logic [DIST_W-1:0] r;
        r = '0;
        for (int k = 1; k <= ROOT_MAX; k++)
        begin
            if (8'(k * k) <= s)
            begin
                r = DIST_W'(k);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/banded_distance_map_splat.sv
// A splat visits (2D+1)^2 neighbors in the plane and (2D+1)^3 for a cube; a clear sweeps
// every 16-entry memory word (65536 words at the default size). One neighbor
// read-modify-write enters the map memory per cycle; items are taken one at a time.
// After reset the map memory is swept to the value 2, word by word, before the first item
// is accepted; configuration writes are taken.
module banded_distance_map_splat
    import bdms_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int MAX_DIST   = DEF_MAX_DIST
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [7:0]        pos_x,
    input  logic [7:0]        pos_y,
    input  logic [3:0]        pos_z,
    input  logic [15:0]       pixel_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DIST_W-1:0] distance,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam longint MAP_SIZE = longint'(MAX_WIDTH) * MAX_HEIGHT * MAX_DEPTH;
    localparam int     WORDS    = int'((MAP_SIZE + LANES - 1) / LANES);
    localparam int     WAW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int     AW       = WAW + LANE_W;
    localparam int     RW       = (MAX_HEIGHT * MAX_DEPTH > 1) ? $clog2(MAX_HEIGHT * MAX_DEPTH) : 1;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [WAW-1:0]    sweep_reg, sweep_next;
    logic [DIST_W-1:0] fill_val_reg, fill_val_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        cx_reg, cx_next;
    logic [7:0]        cy_reg, cy_next;
    logic [3:0]        cz_reg, cz_next;
    logic [2:0]        rad_reg, rad_next;
    logic [2:0]        radz_reg, radz_next;
    logic [3:0]        ux_reg, ux_next;
    logic [3:0]        uy_reg, uy_next;
    logic [3:0]        uz_reg, uz_next;
    logic              hit_reg, hit_next;

    logic [15:0]       fg_reg;
    logic [2:0]        max_dist_reg;
    logic [1:0]        dim_reg;
    logic [8:0]        width_reg;
    logic [8:0]        height_reg;
    logic [4:0]        depth_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance_reg, distance_next;

    logic              s1v_reg, s2v_reg, s3v_reg;
    logic [7:0]        s1_nx_reg, s1_ny_reg;
    logic [3:0]        s1_nz_reg;
    logic [7:0]        s1_sq_reg;
    logic [RW-1:0]     s2_row_reg;
    logic [7:0]        s2_nx_reg;
    logic [DIST_W-1:0] s2_root_reg;
    logic [AW-1:0]     s3_addr_reg;
    logic [DIST_W-1:0] s3_root_reg;

    logic [2:0]        eff_d;
    logic [8:0]        eff_w;
    logic [8:0]        eff_h;
    logic [4:0]        eff_dp;

    logic              in_acc;
    logic              out_free;
    logic              filling;
    logic [3:0]        two_r, two_rz;
    logic [8:0]        nxo, nyo;
    logic [4:0]        nzo;
    logic              x_ok, y_ok, z_ok;
    logic              cand_v;
    logic              scan_last;
    logic [2:0]        ax, ay, az;
    logic [7:0]        sq;
    logic [DIST_W-1:0] result;

    map_req_t          map_req;
    logic [AW-1:0]     map_addr;
    map_stat_t         map_stat;

    // Register values outside their range are clamped, as the block defines them.
    always_comb
    begin
        if (max_dist_reg == 3'd0)
            eff_d = 3'd1;
        else if (32'(max_dist_reg) > MAX_DIST)
            eff_d = 3'(MAX_DIST);
        else
            eff_d = max_dist_reg;

        if (width_reg == 9'd0)
            eff_w = 9'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = 9'(MAX_WIDTH);
        else
            eff_w = width_reg;

        if (height_reg == 9'd0)
            eff_h = 9'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = 9'(MAX_HEIGHT);
        else
            eff_h = height_reg;

        if (depth_reg == 5'd0)
            eff_dp = 5'd1;
        else if (32'(depth_reg) > MAX_DEPTH)
            eff_dp = 5'(MAX_DEPTH);
        else
            eff_dp = depth_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign filling   = (state_reg == ST_INIT) || (state_reg == ST_FILL);
    assign cfg_ready = 1'b1;

    // Neighbor generator: offsets run from 0 to 2r, the neighbor sits at center + offset - r.
    assign two_r  = {rad_reg, 1'b0};
    assign two_rz = {radz_reg, 1'b0};
    assign nxo    = 9'(cx_reg) + 9'(ux_reg);
    assign nyo    = 9'(cy_reg) + 9'(uy_reg);
    assign nzo    = 5'(cz_reg) + 5'(uz_reg);
    assign x_ok   = (nxo >= 9'(rad_reg)) && ({1'b0, nxo} < ({1'b0, eff_w} + 10'(rad_reg)));
    assign y_ok   = (nyo >= 9'(rad_reg)) && ({1'b0, nyo} < ({1'b0, eff_h} + 10'(rad_reg)));
    assign z_ok   = (nzo >= 5'(radz_reg)) && ({1'b0, nzo} < ({1'b0, eff_dp} + 6'(radz_reg)));
    assign cand_v = (state_reg == ST_SCAN) && x_ok && y_ok && z_ok;
    assign scan_last = (ux_reg == two_r) && (uy_reg == two_r) && (uz_reg == two_rz);

    assign ax = (ux_reg >= {1'b0, rad_reg}) ? 3'(ux_reg - {1'b0, rad_reg})
                                            : 3'({1'b0, rad_reg} - ux_reg);
    assign ay = (uy_reg >= {1'b0, rad_reg}) ? 3'(uy_reg - {1'b0, rad_reg})
                                            : 3'({1'b0, rad_reg} - uy_reg);
    assign az = (uz_reg >= {1'b0, radz_reg}) ? 3'(uz_reg - {1'b0, radz_reg})
                                             : 3'({1'b0, radz_reg} - uz_reg);
    assign sq = 8'(ax) * 8'(ax) + 8'(ay) * 8'(ay) + 8'(az) * 8'(az);

    assign result = ((op_reg == OP_READ) && hit_reg) ? map_stat.rd_value : '0;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        fill_val_next  = fill_val_reg;
        op_next        = op_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        rad_next       = rad_reg;
        radz_next      = radz_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        uz_next        = uz_reg;
        hit_next       = hit_reg || cand_v;
        out_valid_next = out_valid_reg && out_stall;
        distance_next  = distance_reg;

        case (state_reg)
            ST_INIT:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next    = opcode;
                    cx_next    = pos_x;
                    cy_next    = pos_y;
                    cz_next    = pos_z;
                    ux_next    = '0;
                    uy_next    = '0;
                    uz_next    = '0;
                    hit_next   = 1'b0;
                    sweep_next = '0;
                    rad_next   = '0;
                    radz_next  = '0;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            fill_val_next = DIST_W'(eff_d) + DIST_W'(1);
                            state_next    = ST_FILL;
                        end
                        OP_PIXEL:
                        begin
                            if (pixel_value == fg_reg)
                            begin
                                rad_next   = eff_d;
                                radz_next  = (dim_reg == DIM_CUBE) ? eff_d : 3'd0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            // A read is a scan of radius zero: one candidate, bounds-checked.
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (ux_reg != two_r)
                begin
                    ux_next = ux_reg + 1'b1;
                end
                else if (uy_reg != two_r)
                begin
                    ux_next = '0;
                    uy_next = uy_reg + 1'b1;
                end
                else
                begin
                    ux_next = '0;
                    uy_next = '0;
                    uz_next = uz_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1v_reg && !s2v_reg && !s3v_reg && !map_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            fill_val_reg  <= RST_FILL;
            op_reg        <= OP_CLEAR;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            s1v_reg       <= 1'b0;
            s2v_reg       <= 1'b0;
            s3v_reg       <= 1'b0;
            fg_reg        <= RST_FOREGROUND;
            max_dist_reg  <= RST_MAX_DIST;
            dim_reg       <= RST_DIM;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            depth_reg     <= RST_DEPTH;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            fill_val_reg  <= fill_val_next;
            op_reg        <= op_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            s1v_reg       <= cand_v;
            s2v_reg       <= s1v_reg;
            s3v_reg       <= s2v_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOREGROUND: fg_reg       <= cfg_data;
                    CFG_MAX_DIST:   max_dist_reg <= cfg_data[2:0];
                    CFG_DIM:        dim_reg      <= cfg_data[1:0];
                    CFG_WIDTH:      width_reg    <= cfg_data[8:0];
                    CFG_HEIGHT:     height_reg   <= cfg_data[8:0];
                    CFG_DEPTH:      depth_reg    <= cfg_data[4:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        rad_reg      <= rad_next;
        radz_reg     <= radz_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        uz_reg       <= uz_next;
        distance_reg <= distance_next;

        s1_nx_reg    <= 8'(nxo - 9'(rad_reg));
        s1_ny_reg    <= 8'(nyo - 9'(rad_reg));
        s1_nz_reg    <= 4'(nzo - 5'(radz_reg));
        s1_sq_reg    <= sq;

        s2_row_reg   <= RW'(64'(s1_nz_reg) * 64'(MAX_HEIGHT) + 64'(s1_ny_reg));
        s2_nx_reg    <= s1_nx_reg;
        s2_root_reg  <= root_of(s1_sq_reg);

        s3_addr_reg  <= AW'(64'(s2_row_reg) * 64'(MAX_WIDTH) + 64'(s2_nx_reg));
        s3_root_reg  <= s2_root_reg;
    end

    always_comb
    begin
        if (filling)
        begin
            map_req.kind  = REQ_FILL;
            map_req.value = fill_val_reg;
            map_addr      = {sweep_reg, LANE_W'(0)};
        end
        else
        begin
            if (!s3v_reg)
                map_req.kind = REQ_NONE;
            else if (op_reg == OP_READ)
                map_req.kind = REQ_READ;
            else
                map_req.kind = REQ_RMW;
            map_req.value = s3_root_reg;
            map_addr      = s3_addr_reg;
        end
    end

    bdms_map #(
        .WORDS (WORDS),
        .WAW   (WAW)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .addr  (map_addr),
        .stat  (map_stat)
    );

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule

FILE: rtl/bdms_map.sv
module bdms_map
    import bdms_pkg::*;
#(
    parameter int WORDS = 65536,
    parameter int WAW   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  map_req_t              req,
    input  logic [WAW+LANE_W-1:0] addr,
    output map_stat_t             stat
);

    localparam int WORD_W = LANES * DIST_W;

    logic [WORD_W-1:0] mem [WORDS];

    logic [WAW-1:0]    word_a;
    logic [LANE_W-1:0] lane_a;

    req_kind_t         s4_kind_reg;
    logic [WAW-1:0]    s4_word_reg;
    logic [LANE_W-1:0] s4_lane_reg;
    logic [DIST_W-1:0] s4_value_reg;
    logic [WORD_W-1:0] rd_word_reg;

    logic              fwd_v_reg;
    logic              fwd_v_next;
    logic [WAW-1:0]    fwd_word_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic [DIST_W-1:0] rd_value_reg;

    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] new_word;
    logic [DIST_W-1:0] old_value;

    assign word_a = addr[WAW+LANE_W-1:LANE_W];
    assign lane_a = addr[LANE_W-1:0];

    // The word written back last cycle is not yet visible to a read issued in that cycle.
    assign cur_word  = (fwd_v_reg && (fwd_word_reg == s4_word_reg)) ? fwd_data_reg : rd_word_reg;
    assign old_value = cur_word[s4_lane_reg*DIST_W +: DIST_W];

    always_comb
    begin
        new_word = cur_word;
        if (s4_value_reg < old_value)
        begin
            new_word[s4_lane_reg*DIST_W +: DIST_W] = s4_value_reg;
        end
    end

    assign fwd_v_next = (s4_kind_reg == REQ_RMW);

    always_ff @(posedge clk)
    begin
        if (s4_kind_reg == REQ_RMW)
        begin
            mem[s4_word_reg] <= new_word;
        end
        else if (req.kind == REQ_FILL)
        begin
            mem[word_a] <= {LANES{req.value}};
        end
        if ((req.kind == REQ_RMW) || (req.kind == REQ_READ))
        begin
            rd_word_reg <= mem[word_a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_kind_reg <= REQ_NONE;
            fwd_v_reg   <= 1'b0;
        end
        else
        begin
            s4_kind_reg <= (req.kind == REQ_FILL) ? REQ_NONE : req.kind;
            fwd_v_reg   <= fwd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_word_reg  <= word_a;
        s4_lane_reg  <= lane_a;
        s4_value_reg <= req.value;
        fwd_word_reg <= s4_word_reg;
        fwd_data_reg <= new_word;
        if (s4_kind_reg == REQ_READ)
        begin
            rd_value_reg <= old_value;
        end
    end

    assign stat.busy     = (s4_kind_reg != REQ_NONE);
    assign stat.rd_value = rd_value_reg;

endmodule

FILE: rtl/bdms_checker.sv
module bdms_checker
    import bdms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DIST_W-1:0] distance
);

    // A result held back by the consumer keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(distance)))
        else $error("stalled result changed");

    // No entry ever exceeds the widest band plus one.
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance <= MAX_ENTRY_VALUE))
        else $error("distance above band limit");

    // Items are processed one at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while busy");

    // A new result only appears at the end of an item's work.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

endmodule

bind banded_distance_map_splat bdms_checker u_bdms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .distance  (distance)
);

FILE: tb/sv/tb_top.sv
module tb_top;
    import bdms_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] CFG_SPARE = 3'd7;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 20;
    // A clear sweeps 65536 words; allow several times that with no handshake at all.
    localparam int WATCHDOG_LIMIT  = 280000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [3:0]  z;
        logic [15:0] pix;
    } pixel_item_t;

    typedef struct packed {
        logic        is_reg;
        pixel_item_t item;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        logic        typed;
        logic [3:0]  want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode = OP_CLEAR;
    logic [7:0]        pos_x = '0;
    logic [7:0]        pos_y = '0;
    logic [3:0]        pos_z = '0;
    logic [15:0]       pixel_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DIST_W-1:0] distance;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = CFG_FOREGROUND;
    logic [15:0]       cfg_data = '0;

    // Predictor state: register copies and a sparse copy of the distance map.
    logic [15:0] fg_reg;
    logic [2:0]  radius_reg;
    logic [1:0]  dim_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [4:0]  depth_reg;
    logic [3:0]  band_fill;
    logic [3:0]  band_map [int];

    logic [3:0]  pending_distances [$];
    logic [3:0]  oldest_distance;
    plan_row_t   directed_plan [$];

    int hot_x = 0;
    int hot_y = 0;
    int hot_z = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int splat_count = 0;
    int clear_count = 0;
    int stuck_cycles = 0;
    logic hold_request = 1'b0;
    logic quiet_tail = 1'b0;

    banded_distance_map_splat u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance    (distance),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_size(int v, int hi);
        if (v < 1)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [3:0] floor_root(int s);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= s)
        begin
            r++;
        end
        return 4'(r);
    endfunction

    function automatic int map_key(int x, int y, int z);
        return (z * DEF_MAX_HEIGHT + y) * DEF_MAX_WIDTH + x;
    endfunction

    function automatic logic [3:0] map_entry(int key);
        return band_map.exists(key) ? band_map[key] : band_fill;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            CFG_FOREGROUND: fg_reg = data;
            CFG_MAX_DIST:   radius_reg = data[2:0];
            CFG_DIM:        dim_reg = data[1:0];
            CFG_WIDTH:      width_reg = data[8:0];
            CFG_HEIGHT:     height_reg = data[8:0];
            CFG_DEPTH:      depth_reg = data[4:0];
            default:        ;
        endcase
    endfunction

    function automatic void splat_at(int cx, int cy, int cz);
        int d, w, h, dp, dzr, nx, ny, nz, key;
        logic [3:0] r;
        d = clamp_size(radius_reg, DEF_MAX_DIST);
        w = clamp_size(width_reg, DEF_MAX_WIDTH);
        h = clamp_size(height_reg, DEF_MAX_HEIGHT);
        dp = clamp_size(depth_reg, DEF_MAX_DEPTH);
        dzr = (dim_reg == DIM_CUBE) ? d : 0;
        splat_count++;
        for (int dz = -dzr; dz <= dzr; dz++)
        begin
            nz = cz + dz;
            if (nz < 0 || nz >= dp)
            begin
                continue;
            end
            for (int dy = -d; dy <= d; dy++)
            begin
                ny = cy + dy;
                if (ny < 0 || ny >= h)
                begin
                    continue;
                end
                for (int dx = -d; dx <= d; dx++)
                begin
                    nx = cx + dx;
                    if (nx < 0 || nx >= w)
                    begin
                        continue;
                    end
                    key = map_key(nx, ny, nz);
                    r = floor_root(dx * dx + dy * dy + dz * dz);
                    if (r < map_entry(key))
                    begin
                        band_map[key] = r;
                    end
                end
            end
        end
    endfunction

    function automatic logic [3:0] predict_distance(pixel_item_t it);
        case (it.op)
            OP_CLEAR:
            begin
                band_map.delete();
                band_fill = 4'(clamp_size(radius_reg, DEF_MAX_DIST) + 1);
                clear_count++;
            end
            OP_PIXEL:
            begin
                if (it.pix == fg_reg)
                begin
                    splat_at(it.x, it.y, it.z);
                end
            end
            OP_READ:
            begin
                if (it.x < clamp_size(width_reg, DEF_MAX_WIDTH) &&
                    it.y < clamp_size(height_reg, DEF_MAX_HEIGHT) &&
                    it.z < clamp_size(depth_reg, DEF_MAX_DEPTH))
                begin
                    return map_entry(map_key(it.x, it.y, it.z));
                end
            end
            default: ;
        endcase
        return 4'd0;
    endfunction

    function automatic void plan_item(logic [1:0] op, int x, int y, int z, logic [15:0] pix,
                                      logic typed, logic [3:0] want);
        plan_row_t row;
        row = '0;
        row.item.op = op;
        row.item.x = 8'(x);
        row.item.y = 8'(y);
        row.item.z = 4'(z);
        row.item.pix = pix;
        row.typed = typed;
        row.want = want;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_reg(logic [2:0] idx, logic [15:0] data);
        plan_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        directed_plan.push_back(row);
    endfunction

    // Upper bits beyond the register width carry junk; the block must ignore them.
    function automatic logic [15:0] with_noise(int value, int width);
        logic [15:0] junk;
        junk = 16'($urandom());
        return (width >= 16) ? 16'(value) : ((junk << width) | 16'(value));
    endfunction

    function automatic pixel_item_t random_item(int fg_pct);
        pixel_item_t it;
        int pick, w, h, dp, d;
        w = clamp_size(width_reg, DEF_MAX_WIDTH);
        h = clamp_size(height_reg, DEF_MAX_HEIGHT);
        dp = clamp_size(depth_reg, DEF_MAX_DEPTH);
        d = clamp_size(radius_reg, DEF_MAX_DIST);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            it.op = OP_READ;
        end
        else if (pick < 97)
        begin
            it.op = OP_PIXEL;
        end
        else
        begin
            it.op = OP_UNUSED;
        end
        it.pix = 16'($urandom());
        if (it.op == OP_PIXEL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < fg_pct)
            begin
                it.pix = fg_reg;
            end
            else if (pick < fg_pct + 15)
            begin
                it.pix = fg_reg ^ (16'd1 << $urandom_range(0, 15));
            end
        end
        // Half of the reads probe the band around the latest foreground pixel.
        pick = $urandom_range(0, 9);
        if (pick < 5 && it.op == OP_READ)
        begin
            it.x = 8'(hot_x + int'($urandom_range(0, 2 * d + 2)) - (d + 1));
            it.y = 8'(hot_y + int'($urandom_range(0, 2 * d + 2)) - (d + 1));
            it.z = 4'(hot_z + int'($urandom_range(0, 2)) - 1);
        end
        else if (pick < 8)
        begin
            it.x = 8'($urandom_range(0, w - 1));
            it.y = 8'($urandom_range(0, h - 1));
            it.z = 4'($urandom_range(0, dp - 1));
        end
        else
        begin
            it.x = 8'($urandom_range(0, 255));
            it.y = 8'($urandom_range(0, 255));
            it.z = 4'($urandom_range(0, 15));
        end
        if (it.op == OP_PIXEL && it.pix == fg_reg)
        begin
            hot_x = it.x;
            hot_y = it.y;
            hot_z = it.z;
        end
        return it;
    endfunction

    // Leaves in_valid high so that a following item goes out back to back.
    task automatic send_item(input pixel_item_t it, input logic typed, input logic [3:0] want);
        logic [3:0] model;
        opcode <= it.op;
        pos_x <= it.x;
        pos_y <= it.y;
        pos_z <= it.z;
        pixel_value <= it.pix;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        model = predict_distance(it);
        pending_distances.push_back(typed ? want : model);
        items_sent++;
    endtask

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, data);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual distance %0d",
                         $time, distance);
                errors++;
            end
            else
            begin
                oldest_distance = pending_distances.pop_front();
                results_checked++;
                if (distance !== oldest_distance)
                begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, oldest_distance, distance);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Result side back-pressure: short bursts, calm stretches and one long hold-off.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 30) == 0)
            begin
                repeat ($urandom_range(20, 120)) @(posedge clk);
            end
        end
    end

    initial
    begin
        plan_row_t row;
        pixel_item_t clear_item;
        logic reg_open;
        int p_dim, p_rad, p_w, p_h, p_dp, p_fg, fg_pct;

        fg_reg = RST_FOREGROUND;
        radius_reg = RST_MAX_DIST;
        dim_reg = RST_DIM;
        width_reg = RST_WIDTH;
        height_reg = RST_HEIGHT;
        depth_reg = RST_DEPTH;
        band_fill = RST_FILL;
        clear_item = '0;
        clear_item.op = OP_CLEAR;
        reg_open = 1'b0;

        // Reset settings: one plane of 256 x 256, radius 1, foreground 1.
        plan_item(OP_READ, 0, 0, 0, 16'h0000, 1'b1, RST_FILL);
        plan_item(OP_READ, 255, 255, 0, 16'h0000, 1'b1, RST_FILL);
        plan_item(OP_READ, 0, 0, 1, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_UNUSED, 255, 255, 15, 16'hffff, 1'b1, 4'd0);
        plan_item(OP_PIXEL, 0, 0, 0, 16'h0001, 1'b1, 4'd0);
        plan_item(OP_READ, 0, 0, 0, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_READ, 1, 1, 0, 16'h0000, 1'b1, 4'd1);
        plan_item(OP_READ, 2, 0, 0, 16'h0000, 1'b1, RST_FILL);
        // A pixel on a slice outside the image splats, but no neighbor lands inside.
        plan_item(OP_PIXEL, 255, 255, 15, 16'h0001, 1'b1, 4'd0);
        plan_item(OP_READ, 255, 255, 0, 16'h0000, 1'b1, RST_FILL);
        plan_item(OP_PIXEL, 255, 255, 0, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_READ, 255, 254, 0, 16'h0000, 1'b1, RST_FILL);
        // Widest radius as a cube over the full volume.
        plan_reg(CFG_FOREGROUND, 16'hffff);
        plan_reg(CFG_MAX_DIST, 16'd7);
        plan_reg(CFG_DIM, 16'(DIM_CUBE));
        plan_reg(CFG_DEPTH, 16'd16);
        plan_item(OP_CLEAR, 0, 0, 0, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_PIXEL, 7, 7, 7, 16'hffff, 1'b1, 4'd0);
        plan_item(OP_READ, 7, 7, 7, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_READ, 0, 7, 7, 16'h0000, 1'b1, 4'd7);
        plan_item(OP_READ, 0, 0, 0, 16'h0000, 1'b1, MAX_ENTRY_VALUE);
        plan_item(OP_READ, 255, 255, 15, 16'h0000, 1'b1, MAX_ENTRY_VALUE);
        plan_item(OP_READ, 3, 4, 5, 16'h0000, 1'b0, 4'd0);
        // Zero sizes and radius act as one; the fill of the last clear stays.
        plan_reg(CFG_MAX_DIST, 16'd0);
        plan_reg(CFG_DIM, 16'd0);
        plan_reg(CFG_WIDTH, 16'd0);
        plan_reg(CFG_HEIGHT, 16'd0);
        plan_reg(CFG_DEPTH, 16'd0);
        plan_item(OP_READ, 1, 0, 0, 16'h0000, 1'b1, 4'd0);
        plan_item(OP_READ, 0, 0, 0, 16'h0000, 1'b1, MAX_ENTRY_VALUE);
        plan_item(OP_PIXEL, 1, 1, 0, 16'hffff, 1'b1, 4'd0);
        plan_item(OP_READ, 0, 0, 0, 16'h0000, 1'b1, 4'd1);
        // Oversized values saturate to the storage size.
        plan_reg(CFG_WIDTH, 16'd511);
        plan_reg(CFG_HEIGHT, 16'd511);
        plan_reg(CFG_DEPTH, 16'd31);
        plan_reg(CFG_MAX_DIST, 16'd7);
        plan_reg(CFG_DIM, 16'd1);
        plan_reg(CFG_SPARE, 16'hffff);
        plan_item(OP_READ, 7, 7, 6, 16'h0000, 1'b1, 4'd1);
        plan_item(OP_READ, 255, 255, 15, 16'h0000, 1'b1, MAX_ENTRY_VALUE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_plan.size(); i++)
        begin
            row = directed_plan[i];
            if (row.is_reg)
            begin
                if (!reg_open && items_sent != 0)
                begin
                    wait_for_results();
                end
                write_reg(row.reg_idx, row.reg_data);
                reg_open = 1'b1;
            end
            else
            begin
                if (reg_open)
                begin
                    cfg_valid <= 1'b0;
                    reg_open = 1'b0;
                end
                send_item(row.item, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            quiet_tail = (p == PHASES - 1);
            p_dim = 2;
            p_rad = $urandom_range(1, 4);
            p_w = $urandom_range(1, 40);
            p_h = $urandom_range(1, 40);
            p_dp = $urandom_range(1, 8);
            p_fg = $urandom_range(0, 65535);
            fg_pct = 50;
            case (p)
                0:
                begin
                    p_rad = $urandom_range(0, 7);
                    p_w = $urandom_range(1, 48);
                    p_h = $urandom_range(1, 48);
                    p_dp = $urandom_range(1, 16);
                end
                1:
                begin
                    p_dim = DIM_CUBE;
                    p_rad = $urandom_range(1, 2);
                    p_w = $urandom_range(2, 24);
                    p_h = $urandom_range(2, 24);
                    p_dp = $urandom_range(2, 16);
                end
                2:
                begin
                    p_rad = 7;
                    case ($urandom_range(0, 3))
                        0: p_w = 0;
                        1: p_w = 1;
                        2: p_w = 256;
                        default: p_w = $urandom_range(257, 511);
                    endcase
                    p_h = $urandom_range(1, 32);
                    p_dp = $urandom_range(1, 4);
                    fg_pct = 40;
                end
                3:
                begin
                    // Full cubes are costly, so foreground pixels are rare here.
                    p_dim = DIM_CUBE;
                    p_rad = 7;
                    p_w = $urandom_range(8, 40);
                    p_h = $urandom_range(8, 40);
                    p_dp = 31;
                    fg_pct = 4;
                end
                4:
                begin
                    p_dim = $urandom_range(0, 2);
                    p_rad = $urandom_range(1, 3);
                    p_w = $urandom_range(1, 64);
                    p_h = $urandom_range(1, 64);
                    p_dp = $urandom_range(1, 16);
                    p_fg = 0;
                end
                5:
                begin
                    p_dim = DIM_CUBE;
                    p_rad = $urandom_range(0, 2);
                    p_w = $urandom_range(1, 32);
                    p_h = $urandom_range(1, 32);
                    p_dp = $urandom_range(0, 31);
                end
                6:
                begin
                    p_rad = $urandom_range(1, 7);
                    p_w = $urandom_range(0, 511);
                    p_h = $urandom_range(0, 511);
                    p_dp = $urandom_range(0, 31);
                    p_fg = 16'hffff;
                end
                default: ;
            endcase
            write_reg(CFG_FOREGROUND, with_noise(p_fg, 16));
            write_reg(CFG_MAX_DIST, with_noise(p_rad, 3));
            write_reg(CFG_DIM, with_noise(p_dim, 2));
            write_reg(CFG_WIDTH, with_noise(p_w, 9));
            write_reg(CFG_HEIGHT, with_noise(p_h, 9));
            write_reg(CFG_DEPTH, with_noise(p_dp, 5));
            cfg_valid <= 1'b0;
            if (p % 2 == 0)
            begin
                send_item(clear_item, 1'b0, 4'd0);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 1 && n == 40)
                begin
                    hold_request = 1'b1;
                end
                if (p == 3 && n == 120)
                begin
                    wait_for_results();
                end
                if (!quiet_tail && !(n >= 100 && n < 160) && $urandom_range(0, 4) == 0)
                begin
                    idle_input($urandom_range(1, 15));
                end
                send_item(random_item(fg_pct), 1'b0, 4'd0);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_distances.size() != 0)
        begin
            errors++;
        end
        $display("Sent %0d items over %0d register settings: %0d splats, %0d clears.",
                 items_sent, PHASES + 4, splat_count, clear_count);
        $display("Checked %0d distances, %0d mismatches.", results_checked, errors);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bdms_pkg.sv
rtl/bdms_map.sv
rtl/banded_distance_map_splat.sv
rtl/bdms_checker.sv
tb/sv/tb_top.sv
